// ===== sv/dcsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcsd_pkg
// Shared types and codes of the delta coordinate sequence decoder.
// ----------------------------------------------------------------------------
package dcsd_pkg;

	// Largest usable node count; node_count is clamped to 1..MAX_NODES
	localparam logic [15:0] MAX_NODES = 16'hFFFF;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DELTA_SIZE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HAS_SERIALS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT  = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_POINT  = 2'd0;
	localparam logic [1:0] KIND_SERIAL = 2'd1;
	localparam logic [1:0] KIND_BOX    = 2'd2;
	localparam logic [1:0] KIND_END    = 2'd3;

	// Work passed from the parser to the executor
	typedef enum logic [1:0] {
		CMD_HEAD,
		CMD_DELTA,
		CMD_SERIAL,
		CMD_END
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t     op;
		logic [15:0] node_index;
		logic [31:0] val_a;      // start latitude or latitude delta
		logic [31:0] val_b;      // start longitude or longitude delta
		logic [7:0]  serial;
		logic        finish;     // bounding box follows this point
		logic        last;       // final result (box last flag for points)
	} cmd_t;

endpackage

// ===== sv/dcsd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcsd_if
// Byte, result and configuration channels of the decoder.
// ----------------------------------------------------------------------------
interface dcsd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface dcsd_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] node_index;
	logic [31:0] lat_value;
	logic [31:0] lon_value;
	logic [31:0] lat_max;
	logic [31:0] lon_max;
	logic [7:0]  serial;
	logic        last;

	modport source (output valid, output kind, output node_index, output lat_value,
		output lon_value, output lat_max, output lon_max, output serial, output last,
		input ready);
	modport sink (input valid, input kind, input node_index, input lat_value,
		input lon_value, input lat_max, input lon_max, input serial, input last,
		output ready);
endinterface

interface dcsd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/dcsd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcsd_front
// Byte parser: holds the configuration registers, tracks the stream phase,
// assembles head and delta records and flag groups, and issues commands.
// ----------------------------------------------------------------------------
module dcsd_front import dcsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	dcsd_byte_if.sink  bytes,
	dcsd_cfg_if.sink   cfg,
	output logic       push,
	output cmd_t       push_cmd,
	input  logic       full
);

	localparam logic [2:0] PH_HEAD   = 3'd0;
	localparam logic [2:0] PH_DELTA  = 3'd1;
	localparam logic [2:0] PH_FLAG   = 3'd2;
	localparam logic [2:0] PH_SERIAL = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	function automatic logic [31:0] sext(input logic [23:0] raw, input logic [1:0] n);
		logic [31:0] r;
		case (n)
			2'd1:    r = {{24{raw[7]}}, raw[7:0]};
			2'd2:    r = {{16{raw[15]}}, raw[15:0]};
			default: r = {{8{raw[23]}}, raw};
		endcase
		return r;
	endfunction

	// Lowest set bit among 0..6, else 7
	function automatic logic [2:0] lowest_bit(input logic [7:0] v);
		logic [2:0] p;
		p = 3'd7;
		for (int i = 6; i >= 0; i--) begin
			if (v[i]) p = 3'(i);
		end
		return p;
	endfunction

	logic [1:0]  delta_size_q;
	logic        has_serials_q;
	logic [15:0] node_count_q;

	logic [2:0]  phase_q, phase_d;
	logic [2:0]  bir_q, bir_d;
	logic [15:0] pidx_q, pidx_d;
	logic [47:0] head_q, head_d;
	logic [47:0] delta_q, delta_d;
	logic [7:0]  flag_q, flag_d;
	logic [2:0]  pos_q, pos_d;

	logic        take;
	logic [7:0]  b;
	logic [15:0] cnt;
	logic [1:0]  nb;
	logic [2:0]  rec;
	logic [2:0]  bir_inc;
	logic [47:0] db;
	logic [23:0] or_raw;
	logic [15:0] pidx_inc;
	logic [15:0] pidx_p8;
	logic        fin_delta;
	logic [15:0] rem;
	logic        final_grp;
	logic [7:0]  gmask;
	logic [7:0]  fmask;
	logic [7:0]  flag_clr;
	logic        push_c;
	cmd_t        cmd_c;

	assign cfg.ready   = 1'b1;
	assign bytes.ready = !full;
	assign take        = bytes.valid && !full;
	assign b           = bytes.data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_size_q  <= 2'd1;
			has_serials_q <= 1'b0;
			node_count_q  <= 16'd1;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DELTA_SIZE:  delta_size_q  <= cfg.data[1:0];
				REG_HAS_SERIALS: has_serials_q <= cfg.data[0];
				REG_NODE_COUNT:  node_count_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (node_count_q == 16'd0)          cnt = 16'd1;
		else if (node_count_q > MAX_NODES)  cnt = MAX_NODES;
		else                                cnt = node_count_q;
	end

	assign nb      = (delta_size_q >= 2'd2) ? 2'd3 : delta_size_q + 2'd1;
	assign rec     = {nb, 1'b0};
	assign bir_inc = (bir_q < 3'd7) ? bir_q + 3'd1 : bir_q;
	assign db      = (bir_q < 3'd6) ? (delta_q | (48'(b) << {bir_q, 3'b000})) : delta_q;

	always_comb begin
		case (nb)
			2'd1:    or_raw = db[31:8];
			2'd2:    or_raw = db[39:16];
			default: or_raw = db[47:24];
		endcase
	end

	assign pidx_inc  = pidx_q + 16'd1;
	assign pidx_p8   = pidx_q + 16'd8;
	assign fin_delta = ({1'b0, pidx_inc} + 17'd1) >= {1'b0, cnt};

	// Usable bits of the current flag group
	assign rem       = (pidx_q < cnt) ? cnt - pidx_q : 16'd0;
	assign final_grp = rem <= 16'd8;
	assign gmask     = (rem >= 16'd8) ? 8'hFF : ((8'd1 << rem[2:0]) - 8'd1);
	assign fmask     = b & gmask;
	assign flag_clr  = flag_q & ~(8'd1 << pos_q);

	always_comb begin
		phase_d = phase_q;
		bir_d   = bir_q;
		pidx_d  = pidx_q;
		head_d  = head_q;
		delta_d = delta_q;
		flag_d  = flag_q;
		pos_d   = pos_q;
		push_c  = 1'b0;
		cmd_c   = '{op: CMD_END, node_index: 16'd0, val_a: 32'd0, val_b: 32'd0,
			serial: 8'd0, finish: 1'b0, last: 1'b0};

		unique case (phase_q)
			PH_HEAD: begin
				if (bir_q >= 3'd6) begin
					push_c       = 1'b1;
					cmd_c.op     = CMD_HEAD;
					cmd_c.val_a  = {4'b0000, b[3:0], head_q[23:0]};
					cmd_c.val_b  = {4'b0000, b[7:4], head_q[47:24]};
					cmd_c.finish = cnt <= 16'd1;
					cmd_c.last   = !has_serials_q;
					bir_d        = 3'd0;
					head_d       = '0;
					pidx_d       = 16'd0;
					if (cnt <= 16'd1) phase_d = has_serials_q ? PH_FLAG : PH_DONE;
					else              phase_d = PH_DELTA;
				end else begin
					head_d = head_q | (48'(b) << {bir_q, 3'b000});
					bir_d  = bir_q + 3'd1;
				end
			end
			PH_DELTA: begin
				delta_d = db;
				bir_d   = bir_inc;
				if (bir_inc >= rec) begin
					push_c           = 1'b1;
					cmd_c.op         = CMD_DELTA;
					cmd_c.node_index = pidx_inc;
					cmd_c.val_a      = sext(db[23:0], nb);
					cmd_c.val_b      = sext(or_raw, nb);
					cmd_c.finish     = fin_delta;
					cmd_c.last       = !has_serials_q;
					bir_d            = 3'd0;
					delta_d          = '0;
					if (fin_delta) begin
						pidx_d  = 16'd0;
						phase_d = has_serials_q ? PH_FLAG : PH_DONE;
					end else begin
						pidx_d  = pidx_inc;
					end
				end
			end
			PH_FLAG: begin
				if (fmask == 8'd0) begin
					if (final_grp) begin
						push_c     = 1'b1;
						cmd_c.op   = CMD_END;
						cmd_c.last = 1'b1;
						phase_d    = PH_DONE;
					end else begin
						pidx_d = pidx_p8;
					end
				end else begin
					flag_d  = fmask;
					pos_d   = lowest_bit(fmask);
					phase_d = PH_SERIAL;
				end
			end
			PH_SERIAL: begin
				push_c           = 1'b1;
				cmd_c.op         = CMD_SERIAL;
				cmd_c.node_index = pidx_q + {13'd0, pos_q};
				cmd_c.serial     = b;
				flag_d           = flag_clr;
				if (flag_clr != 8'd0) begin
					pos_d = lowest_bit(flag_clr);
				end else if (final_grp) begin
					cmd_c.last = 1'b1;
					phase_d    = PH_DONE;
				end else begin
					pidx_d  = pidx_p8;
					phase_d = PH_FLAG;
				end
			end
			default: ; // drop bytes after the end
		endcase
	end

	assign push     = take && push_c;
	assign push_cmd = cmd_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD;
			bir_q   <= 3'd0;
			pidx_q  <= 16'd0;
			head_q  <= '0;
			delta_q <= '0;
			flag_q  <= 8'd0;
			pos_q   <= 3'd0;
		end else if (take) begin
			phase_q <= phase_d;
			bir_q   <= bir_d;
			pidx_q  <= pidx_d;
			head_q  <= head_d;
			delta_q <= delta_d;
			flag_q  <= flag_d;
			pos_q   <= pos_d;
		end
	end

endmodule

// ===== sv/dcsd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcsd_queue
// Small command FIFO between parser and executor.
// ----------------------------------------------------------------------------
module dcsd_queue import dcsd_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_cmd,
	output logic full,
	output logic rd_valid,
	output cmd_t rd_cmd,
	input  logic pop
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full     = count_q == CW'(DEPTH);
	assign rd_valid = count_q != '0;
	assign rd_cmd   = slot_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (do_push && !do_pop)      count_q <= count_q + CW'(1);
			else if (do_pop && !do_push) count_q <= count_q - CW'(1);
		end
	end

endmodule

// ===== sv/dcsd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcsd_back
// Executor: accumulates coordinates, tracks the bounding box and drives the
// registered result channel.
// ----------------------------------------------------------------------------
module dcsd_back import dcsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        pop,
	dcsd_res_if.source  results
);

	logic [31:0] lat_acc_q, lon_acc_q;
	logic [31:0] lat_min_q, lat_max_q, lon_min_q, lon_max_q;
	logic        box_pend_q;
	logic        box_last_q;
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [15:0] idx_q;
	logic [31:0] lat_val_q, lon_val_q, lat_hi_q, lon_hi_q;
	logic [7:0]  serial_q;
	logic        last_q;

	logic        out_free;
	logic        box_load;
	logic [31:0] lat_n, lon_n;

	assign out_free = !out_valid_q || results.ready;
	assign pop      = cmd_valid && !box_pend_q && out_free;
	assign box_load = box_pend_q && out_free;

	assign lat_n = (cmd.op == CMD_HEAD) ? cmd.val_a : lat_acc_q + cmd.val_a;
	assign lon_n = (cmd.op == CMD_HEAD) ? cmd.val_b : lon_acc_q + cmd.val_b;

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q    <= KIND_END;
			idx_q     <= 16'd0;
			lat_val_q <= 32'd0;
			lon_val_q <= 32'd0;
			lat_hi_q  <= 32'd0;
			lon_hi_q  <= 32'd0;
			serial_q  <= 8'd0;
			last_q    <= cmd.last;
			unique case (cmd.op)
				CMD_HEAD: begin
					kind_q    <= KIND_POINT;
					lat_val_q <= lat_n;
					lon_val_q <= lon_n;
					last_q    <= 1'b0;
					lat_acc_q <= lat_n;
					lon_acc_q <= lon_n;
					lat_min_q <= lat_n;
					lat_max_q <= lat_n;
					lon_min_q <= lon_n;
					lon_max_q <= lon_n;
				end
				CMD_DELTA: begin
					kind_q    <= KIND_POINT;
					idx_q     <= cmd.node_index;
					lat_val_q <= lat_n;
					lon_val_q <= lon_n;
					last_q    <= 1'b0;
					lat_acc_q <= lat_n;
					lon_acc_q <= lon_n;
					if (lat_n < lat_min_q) lat_min_q <= lat_n;
					if (lat_n > lat_max_q) lat_max_q <= lat_n;
					if (lon_n < lon_min_q) lon_min_q <= lon_n;
					if (lon_n > lon_max_q) lon_max_q <= lon_n;
				end
				CMD_SERIAL: begin
					kind_q   <= KIND_SERIAL;
					idx_q    <= cmd.node_index;
					serial_q <= cmd.serial;
				end
				CMD_END: begin
					kind_q <= KIND_END;
				end
			endcase
			box_last_q <= cmd.last;
		end else if (box_load) begin
			kind_q    <= KIND_BOX;
			idx_q     <= 16'd0;
			lat_val_q <= lat_min_q;
			lon_val_q <= lon_min_q;
			lat_hi_q  <= lat_max_q;
			lon_hi_q  <= lon_max_q;
			serial_q  <= 8'd0;
			last_q    <= box_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			box_pend_q  <= 1'b0;
		end else begin
			if (pop || box_load)    out_valid_q <= 1'b1;
			else if (results.ready) out_valid_q <= 1'b0;
			// hold the box until the point ahead of it has left the output register
			if (pop)           box_pend_q <= cmd.finish &&
				(cmd.op == CMD_HEAD || cmd.op == CMD_DELTA);
			else if (box_load) box_pend_q <= 1'b0;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.kind       = kind_q;
	assign results.node_index = idx_q;
	assign results.lat_value  = lat_val_q;
	assign results.lon_value  = lon_val_q;
	assign results.lat_max    = lat_hi_q;
	assign results.lon_max    = lon_hi_q;
	assign results.serial     = serial_q;
	assign results.last       = last_q;

endmodule

// ===== sv/delta_coord_sequence_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_coord_sequence_decoder_top
// Delta coordinate sequence decoder: parser, command queue and executor.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle as long as the command queue has room; a
// result passes through the command queue and the output register once the
// byte that completes it is accepted. Each result occupies the output
// register on its own, so the final point of the coordinate section and the
// bounding box behind it leave one after the other, and the QUEUE_DEPTH-entry
// queue between the parser and the executor absorbs the extra box word and
// output stalls up to its depth; longer stalls hold the byte input.
// Configuration registers are written through cfg, which is always ready;
// write them only while the decoder is idle. After the final result all
// further bytes are accepted and dropped until reset.
module delta_coord_sequence_decoder_top import dcsd_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	dcsd_byte_if.sink  bytes,
	dcsd_cfg_if.sink   cfg,
	dcsd_res_if.source results
);

	logic push;
	cmd_t push_cmd;
	logic full;
	logic q_valid;
	cmd_t q_cmd;
	logic pop;

	dcsd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.bytes    (bytes),
		.cfg      (cfg),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full)
	);

	dcsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_cmd   (push_cmd),
		.full     (full),
		.rd_valid (q_valid),
		.rd_cmd   (q_cmd),
		.pop      (pop)
	);

	dcsd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_cmd),
		.pop       (pop),
		.results   (results)
	);

endmodule

// ===== sv/dcsd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcsd_checker
// Port-level checks on the decoder result channel.
// ----------------------------------------------------------------------------
module dcsd_checker import dcsd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [15:0] node_index,
	input logic [31:0] lat_value,
	input logic [31:0] lon_value,
	input logic [31:0] lat_max,
	input logic [31:0] lon_max,
	input logic [7:0]  serial,
	input logic        last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({kind, node_index, lat_value,
			lon_value, lat_max, lon_max, serial, last}))
		else $error("result word changed while stalled");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_END |-> last)
		else $error("end word without last");

	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_BOX |-> lat_value <= lat_max && lon_value <= lon_max
			&& node_index == 16'd0)
		else $error("bounding box min above max");

	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> !out_valid)
		else $error("result after the last word");

endmodule

bind delta_coord_sequence_decoder_top dcsd_checker u_dcsd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.kind       (results.kind),
	.node_index (results.node_index),
	.lat_value  (results.lat_value),
	.lon_value  (results.lon_value),
	.lat_max    (results.lat_max),
	.lon_max    (results.lon_max),
	.serial     (results.serial),
	.last       (results.last)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the delta coordinate sequence decoder. Feeds one
// encoded sequence (head, delta records under changing widths, serial section,
// trailing bytes), predicts every point, box, serial and end word in its own
// decoder model and compares each accepted result field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import dcsd_pkg::*;

	// delta_size register codes
	localparam logic [1:0] DSZ_1B     = 2'd0;
	localparam logic [1:0] DSZ_2B     = 2'd1;
	localparam logic [1:0] DSZ_3B     = 2'd2;
	localparam logic [1:0] DSZ_3B_ALT = 2'd3;

	typedef enum logic [2:0] {
		SEQ_HEAD,
		SEQ_DELTA,
		SEQ_FLAG,
		SEQ_SERIAL,
		SEQ_DONE
	} seq_phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] node_index;
		logic [31:0] lat_value;
		logic [31:0] lon_value;
		logic [31:0] lat_max;
		logic [31:0] lon_max;
		logic [7:0]  serial;
		logic        last;
	} dec_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dcsd_byte_if byte_ch ();
	dcsd_cfg_if  cfg_ch ();
	dcsd_res_if  res_ch ();

	delta_coord_sequence_decoder_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (byte_ch),
		.cfg     (cfg_ch),
		.results (res_ch)
	);

	logic [7:0]  pending_bytes[$];
	dec_result_t expected_results[$];
	int          mismatch_count = 0;
	bit          quiet_bytes = 1'b0;
	bit          quiet_results = 1'b0;
	int          byte_gap = 0;
	int          result_stall = 0;

	// decoder model state and register shadows
	logic [1:0]  cur_delta_size = DSZ_2B;
	logic        cur_has_serials = 1'b0;
	logic [15:0] cur_node_count = 16'd1;
	seq_phase_t  dec_phase = SEQ_HEAD;
	int          rec_pos = 0;
	logic [15:0] pt_idx = '0;
	logic [7:0]  head_buf[7];
	logic [47:0] delta_buf = '0;
	logic [31:0] lat_acc = '0;
	logic [31:0] lon_acc = '0;
	logic [31:0] box_lat_min = '0;
	logic [31:0] box_lat_max = '0;
	logic [31:0] box_lon_min = '0;
	logic [31:0] box_lon_max = '0;
	logic [7:0]  flag_pend = '0;
	logic [2:0]  flag_pos = '0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap(bit quiet);
		int r;
		r = $urandom_range(99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(25, 4);
	endfunction

	function automatic int bytes_per_delta(logic [1:0] dsz);
		return (dsz >= DSZ_3B) ? 3 : int'(dsz) + 1;
	endfunction

	function automatic int eff_nodes();
		if (cur_node_count == 16'd0)
			return 1;
		if (cur_node_count > MAX_NODES)
			return int'(MAX_NODES);
		return int'(cur_node_count);
	endfunction

	function automatic logic [31:0] sign_ext(logic [23:0] raw, int nb);
		case (nb)
			1:       return {{24{raw[7]}}, raw[7:0]};
			2:       return {{16{raw[15]}}, raw[15:0]};
			default: return {{8{raw[23]}}, raw[23:0]};
		endcase
	endfunction

	function automatic logic [2:0] lowest_set(logic [7:0] v);
		int p;
		p = 0;
		while (p < 7 && !v[p])
			p++;
		return 3'(p);
	endfunction

	task automatic group_mask(output logic [7:0] usable, output bit fin);
		int cnt;
		int rem;
		cnt = eff_nodes();
		rem = (int'(pt_idx) < cnt) ? cnt - int'(pt_idx) : 0;
		fin = (rem <= 8);
		usable = (rem >= 8) ? 8'hff : 8'((1 << rem) - 1);
	endtask

	task automatic push_result(logic [1:0] kind, logic [15:0] idx, logic [31:0] a,
		logic [31:0] b, logic [31:0] c, logic [31:0] d, logic [7:0] ser, logic lst);
		dec_result_t r;
		r.kind = kind;
		r.node_index = idx;
		r.lat_value = a;
		r.lon_value = b;
		r.lat_max = c;
		r.lon_max = d;
		r.serial = ser;
		r.last = lst;
		expected_results = {expected_results, r};
	endtask

	task automatic close_coords();
		push_result(KIND_BOX, 16'd0, box_lat_min, box_lon_min, box_lat_max, box_lon_max,
			8'd0, !cur_has_serials);
		pt_idx = '0;
		rec_pos = 0;
		dec_phase = cur_has_serials ? SEQ_FLAG : SEQ_DONE;
	endtask

	task automatic decode_byte(logic [7:0] b);
		int          nb;
		logic [47:0] lon_raw;
		logic [7:0]  usable;
		logic [7:0]  m;
		bit          fin;
		logic [15:0] idx;
		logic        lst;
		case (dec_phase)
			SEQ_HEAD: begin
				if (rec_pos < 7)
					head_buf[rec_pos] = b;
				rec_pos++;
				if (rec_pos >= 7) begin
					lat_acc = {4'h0, head_buf[6][3:0], head_buf[2], head_buf[1], head_buf[0]};
					lon_acc = {4'h0, head_buf[6][7:4], head_buf[5], head_buf[4], head_buf[3]};
					rec_pos = 0;
					pt_idx = '0;
					box_lat_min = lat_acc;
					box_lat_max = lat_acc;
					box_lon_min = lon_acc;
					box_lon_max = lon_acc;
					push_result(KIND_POINT, 16'd0, lat_acc, lon_acc, '0, '0, 8'd0, 1'b0);
					if (eff_nodes() <= 1)
						close_coords();
					else
						dec_phase = SEQ_DELTA;
				end
			end
			SEQ_DELTA: begin
				nb = bytes_per_delta(cur_delta_size);
				if (rec_pos < 6)
					delta_buf[8*rec_pos +: 8] = b;
				if (rec_pos < 7)
					rec_pos++;
				if (rec_pos >= 2 * nb) begin
					lon_raw = delta_buf >> (8 * nb);
					lat_acc = lat_acc + sign_ext(delta_buf[23:0], nb);
					lon_acc = lon_acc + sign_ext(lon_raw[23:0], nb);
					pt_idx = pt_idx + 16'd1;
					if (lat_acc < box_lat_min) box_lat_min = lat_acc;
					if (lat_acc > box_lat_max) box_lat_max = lat_acc;
					if (lon_acc < box_lon_min) box_lon_min = lon_acc;
					if (lon_acc > box_lon_max) box_lon_max = lon_acc;
					push_result(KIND_POINT, pt_idx, lat_acc, lon_acc, '0, '0, 8'd0, 1'b0);
					rec_pos = 0;
					delta_buf = '0;
					if (int'(pt_idx) + 1 >= eff_nodes())
						close_coords();
				end
			end
			SEQ_FLAG: begin
				group_mask(usable, fin);
				m = b & usable;
				if (m == 8'd0) begin
					if (fin) begin
						push_result(KIND_END, 16'd0, '0, '0, '0, '0, 8'd0, 1'b1);
						dec_phase = SEQ_DONE;
					end else begin
						pt_idx = pt_idx + 16'd8;
					end
				end else begin
					flag_pend = m;
					flag_pos = lowest_set(m);
					dec_phase = SEQ_SERIAL;
				end
			end
			SEQ_SERIAL: begin
				idx = pt_idx + 16'(flag_pos);
				group_mask(usable, fin);
				lst = 1'b0;
				flag_pend[flag_pos] = 1'b0;
				if (flag_pend != 8'd0) begin
					flag_pos = lowest_set(flag_pend);
				end else if (fin) begin
					lst = 1'b1;
					dec_phase = SEQ_DONE;
				end else begin
					pt_idx = pt_idx + 16'd8;
					dec_phase = SEQ_FLAG;
				end
				push_result(KIND_SERIAL, idx, '0, '0, '0, '0, b, lst);
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatch_count++;
		$display("%0t ns: %s mismatch, got %h want %h", $time, what, got, want);
	endtask

	task automatic check_result(dec_result_t got);
		dec_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("unexpected word kind", 32'(got.kind), 32'd0);
			return;
		end
		want = expected_results.pop_front();
		if (got.kind != want.kind)
			report_mismatch("kind", 32'(got.kind), 32'(want.kind));
		if (got.node_index != want.node_index)
			report_mismatch("node_index", 32'(got.node_index), 32'(want.node_index));
		if (got.lat_value != want.lat_value)
			report_mismatch("lat_value", got.lat_value, want.lat_value);
		if (got.lon_value != want.lon_value)
			report_mismatch("lon_value", got.lon_value, want.lon_value);
		if (got.lat_max != want.lat_max)
			report_mismatch("lat_max", got.lat_max, want.lat_max);
		if (got.lon_max != want.lon_max)
			report_mismatch("lon_max", got.lon_max, want.lon_max);
		if (got.serial != want.serial)
			report_mismatch("serial", 32'(got.serial), 32'(want.serial));
		if (got.last != want.last)
			report_mismatch("last", 32'(got.last), 32'(want.last));
	endtask

	// byte driver: hold each word until taken, then idle for a random gap
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_ch.valid <= 1'b0;
			byte_ch.data_byte <= 8'd0;
			byte_gap <= 0;
		end else if (!byte_ch.valid || byte_ch.ready) begin
			if (byte_gap != 0) begin
				byte_gap <= byte_gap - 1;
				byte_ch.valid <= 1'b0;
			end else if (pending_bytes.size() != 0) begin
				byte_ch.data_byte <= pending_bytes.pop_front();
				byte_ch.valid <= 1'b1;
				byte_gap <= pick_gap(quiet_bytes);
			end else begin
				byte_ch.valid <= 1'b0;
			end
		end
	end

	// result sink: stall at random
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			result_stall <= 0;
		end else if (result_stall != 0) begin
			result_stall <= result_stall - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
			result_stall <= ($urandom_range(3) == 0) ? pick_gap(quiet_results) : 0;
		end
	end

	// monitor: check results first, then predict from the word taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready)
				check_result({res_ch.kind, res_ch.node_index, res_ch.lat_value,
					res_ch.lon_value, res_ch.lat_max, res_ch.lon_max, res_ch.serial,
					res_ch.last});
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_DELTA_SIZE:  cur_delta_size = cfg_ch.data[1:0];
					REG_HAS_SERIALS: cur_has_serials = cfg_ch.data[0];
					REG_NODE_COUNT:  cur_node_count = cfg_ch.data[15:0];
					default: ;
				endcase
			end
			if (byte_ch.valid && byte_ch.ready)
				decode_byte(byte_ch.data_byte);
		end
	end

	// sample on the falling edge so the driver and monitor have settled
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_bytes.size() != 0 || byte_ch.valid || expected_results.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic queue_record(int nb, logic [31:0] dlat, logic [31:0] dlon);
		for (int i = 0; i < nb; i++)
			pending_bytes = {pending_bytes, dlat[8*i +: 8]};
		for (int i = 0; i < nb; i++)
			pending_bytes = {pending_bytes, dlon[8*i +: 8]};
	endtask

	function automatic logic [31:0] pick_delta(int nb);
		logic [31:0] mask;
		mask = 32'((64'd1 << (8 * nb)) - 1);
		case ($urandom_range(11))
			0:       return mask >> 1;
			1:       return (mask >> 1) + 32'd1;
			2:       return 32'd0;
			3:       return mask;
			default: return $urandom & mask;
		endcase
	endfunction

	initial begin
		int          delta_sent;
		int          nrec;
		int          nb;
		int          nodes;
		int          rem;
		logic [1:0]  dsz;
		logic [7:0]  usable;
		logic [7:0]  flag;

		byte_ch.valid = 1'b0;
		byte_ch.data_byte = 8'd0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_DELTA_SIZE;
		cfg_ch.data = 16'd0;
		res_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: head extremes, one record per width with extreme deltas
		write_reg(REG_DELTA_SIZE, 16'(DSZ_1B));
		write_reg(REG_HAS_SERIALS, 16'd0);
		write_reg(REG_NODE_COUNT, MAX_NODES);
		pending_bytes = '{8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'ha5};
		queue_record(1, 32'h7f, 32'h80);
		wait_idle();
		write_reg(REG_DELTA_SIZE, 16'(DSZ_2B));
		queue_record(2, 32'hffff, 32'h0);
		wait_idle();
		write_reg(REG_DELTA_SIZE, 16'(DSZ_3B));
		queue_record(3, 32'h7fffff, 32'h800000);
		wait_idle();
		write_reg(REG_DELTA_SIZE, 16'(DSZ_3B_ALT));
		queue_record(3, 32'hffffff, 32'h0);

		// random delta segments; each boundary drains all results first
		delta_sent = 0;
		while (delta_sent < 950) begin
			wait_idle();
			quiet_bytes = ($urandom_range(3) == 0);
			quiet_results = ($urandom_range(3) == 0);
			dsz = 2'($urandom_range(3));
			write_reg(REG_DELTA_SIZE, 16'(dsz));
			if ($urandom_range(2) == 0)
				write_reg(REG_NODE_COUNT, ($urandom_range(1) == 0) ? MAX_NODES :
					16'($urandom_range(65535, 1000)));
			if ($urandom_range(3) == 0)
				write_reg(REG_HAS_SERIALS, 16'($urandom_range(1)));
			nb = bytes_per_delta(dsz);
			nrec = $urandom_range(40, 4);
			for (int r = 0; r < nrec; r++)
				queue_record(nb, pick_delta(nb), pick_delta(nb));
			delta_sent += nrec * 2 * nb;
		end

		// close the coordinate section: the next record brings its point and the box
		wait_idle();
		quiet_bytes = 1'b0;
		quiet_results = 1'b0;
		write_reg(REG_HAS_SERIALS, 16'd1);
		write_reg(REG_NODE_COUNT, ($urandom_range(1) == 0) ? 16'd0 : 16'd1);
		nb = bytes_per_delta(cur_delta_size);
		queue_record(nb, pick_delta(nb), pick_delta(nb));

		// serial section over a fresh node count
		wait_idle();
		nodes = $urandom_range(90, 17);
		write_reg(REG_NODE_COUNT, 16'(nodes));
		write_reg(REG_DELTA_SIZE, 16'($urandom_range(3)));
		for (int g = 0; 8 * g < nodes; g++) begin
			rem = nodes - 8 * g;
			usable = (rem >= 8) ? 8'hff : 8'((1 << rem) - 1);
			if (rem <= 8) begin
				// final group: end on a serial or on bits past the last node only
				if ($urandom_range(1) == 0) begin
					flag = 8'($urandom) & usable;
					if (flag == 8'd0)
						flag[rem-1] = 1'b1;
					flag = flag | (8'($urandom) & ~usable);
				end else begin
					flag = 8'($urandom) & ~usable;
				end
			end else begin
				case ($urandom_range(6))
					0:       flag = 8'h00;
					1:       flag = 8'hff;
					default: flag = 8'($urandom);
				endcase
			end
			pending_bytes = {pending_bytes, flag};
			for (int i = 0; i < 8; i++)
				if (flag[i] && usable[i])
					pending_bytes = {pending_bytes, 8'($urandom)};
		end

		// bytes after the end are dropped
		for (int i = 0; i < 10; i++)
			pending_bytes = {pending_bytes, 8'($urandom)};

		do
			@(negedge clk);
		while (pending_bytes.size() != 0 || byte_ch.valid || expected_results.size() != 0);
		repeat (30) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
